/* sv/bdf_pkg.sv */
// Shared types and constants for the push-button debouncer.
`timescale 1ns / 1ps

package bdf_pkg;

  localparam int unsigned CODE_W = 3;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd20;

  localparam logic [CODE_W-1:0] CODE_INACTIVE     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_DB_PRESS     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_ACTIVE       = 3'd2;
  localparam logic [CODE_W-1:0] CODE_WAIT_RELEASE = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DB_RELEASE   = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HOLDABLE       = 1'b1;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic              pressed;
    logic [CODE_W-1:0] state_code;
  } result_t;

endpackage

/* sv/bdf_core.sv */
// Debouncer state machine with its countdown and pressed flag.
`timescale 1ns / 1ps

module bdf_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        kind,
  input  logic                        pin_level,
  input  logic [bdf_pkg::TICK_W-1:0]  debounce_ticks,
  input  logic                        holdable,
  output bdf_pkg::result_t            result_next
);
  import bdf_pkg::*;

  typedef enum logic [CODE_W-1:0] {
    ST_INACTIVE     = CODE_INACTIVE,
    ST_DB_PRESS     = CODE_DB_PRESS,
    ST_ACTIVE       = CODE_ACTIVE,
    ST_WAIT_RELEASE = CODE_WAIT_RELEASE,
    ST_DB_RELEASE   = CODE_DB_RELEASE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [TICK_W-1:0] countdown;
  logic [TICK_W-1:0] countdown_next;
  logic              pressed_flag;
  logic              pressed_flag_next;
  logic              cd_zero;

  assign cd_zero = (countdown == '0);

  always_comb begin
    state_next        = state;
    countdown_next    = countdown;
    pressed_flag_next = pressed_flag;
    if (kind == KIND_TICK) begin
      if (!cd_zero) begin
        countdown_next = countdown - 1'b1;
      end
    end else begin
      unique case (state)
        ST_DB_PRESS: begin
          if (!pin_level) begin
            state_next        = ST_INACTIVE;
            pressed_flag_next = 1'b0;
          end else if (cd_zero) begin
            state_next        = ST_ACTIVE;
            pressed_flag_next = 1'b1;
          end
        end
        ST_ACTIVE: begin
          if (holdable) begin
            if (pin_level) begin
              pressed_flag_next = 1'b1;
            end else begin
              state_next     = ST_DB_RELEASE;
              countdown_next = debounce_ticks;
            end
          end else begin
            state_next        = ST_WAIT_RELEASE;
            pressed_flag_next = 1'b1;
          end
        end
        ST_WAIT_RELEASE: begin
          pressed_flag_next = 1'b0;
          if (!pin_level) begin
            state_next     = ST_DB_RELEASE;
            countdown_next = debounce_ticks;
          end
        end
        ST_DB_RELEASE: begin
          if (pin_level) begin
            state_next        = holdable ? ST_ACTIVE : ST_WAIT_RELEASE;
            pressed_flag_next = holdable;
          end else if (cd_zero) begin
            state_next        = ST_INACTIVE;
            pressed_flag_next = 1'b0;
          end
        end
        default: begin
          pressed_flag_next = 1'b0;
          state_next        = ST_INACTIVE;
          if (pin_level) begin
            state_next     = ST_DB_PRESS;
            countdown_next = debounce_ticks;
          end
        end
      endcase
    end
  end

  assign result_next.pressed    = pressed_flag_next;
  assign result_next.state_code = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INACTIVE;
      countdown    <= '0;
      pressed_flag <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      countdown    <= countdown_next;
      pressed_flag <= pressed_flag_next;
    end
  end

endmodule

/* sv/button_debounce_fsm_top.sv */
// Top level of the push-button debouncer with its output register and settings.
`timescale 1ns / 1ps

// Each input transfer is either a time tick (kind 0) or a button sample (kind 1) and
// gives exactly one result: the debounced pressed flag and the state code after that
// item. One item is taken every cycle while not stalled; its result is registered, and a
// new item is still taken while that result is transferred. Input is stalled only
// while a result waits and the output side stalls. The user writes the debounce tick
// count and holdable mode through the write port only while no item is in flight; the
// block does not enforce this. A new tick count applies at the next debounce load.

module button_debounce_fsm_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic                           pin_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pressed,
  output logic [bdf_pkg::CODE_W-1:0]     state_code,
  input  logic                           wr_en,
  input  logic [bdf_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [bdf_pkg::TICK_W-1:0]     wr_data
);
  import bdf_pkg::*;

  logic              accept;
  logic [TICK_W-1:0] debounce_ticks;
  logic              holdable;
  result_t           result_next;
  result_t           result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= TICKS_RESET;
      holdable       <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= wr_data;
        REG_HOLDABLE:       holdable       <= wr_data[0];
        default:            ;
      endcase
    end
  end

  bdf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .kind           (kind),
    .pin_level      (pin_level),
    .debounce_ticks (debounce_ticks),
    .holdable       (holdable),
    .result_next    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign pressed    = result.pressed;
  assign state_code = result.state_code;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_code_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state_code <= CODE_DB_RELEASE))
    else $error("unused state code on output");

  a_pressed_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pressed) |->
      (state_code != CODE_INACTIVE && state_code != CODE_DB_PRESS))
    else $error("pressed reported in a released state");
`endif

endmodule

/* tb/sv/debounce_result_checker.sv */
// Checker for the push-button debouncer: predicts every result and compares it.
`timescale 1ns / 1ps

module debounce_result_checker
  import bdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 kind,
  input  logic                 pin_level,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 pressed,
  input  logic [CODE_W-1:0]    state_code,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [TICK_W-1:0]    wr_data,
  output int                   errors,
  output int                   outstanding,
  output int                   checked,
  output logic [7:0]           codes_seen
);

  logic [CODE_W-1:0] fsm_code;
  logic [TICK_W-1:0] countdown;
  logic [TICK_W-1:0] ticks_cfg;
  logic              pressed_q;
  logic              holdable_cfg;
  result_t           expected_q[$];

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s: expected %0d, got %0d (result %0d)", $time, what, want_v, got_v,
               checked);
    end
  endtask

  function automatic result_t debounce_step(input logic item_kind, input logic lvl);
    result_t res;
    if (item_kind == KIND_TICK) begin
      if (countdown != '0) countdown = countdown - 1'b1;
    end else begin
      case (fsm_code)
        CODE_DB_PRESS: begin
          if (!lvl) begin
            fsm_code = CODE_INACTIVE;
            pressed_q = 1'b0;
          end else if (countdown == '0) begin
            pressed_q = 1'b1;
            fsm_code = CODE_ACTIVE;
          end
        end
        CODE_ACTIVE: begin
          if (holdable_cfg) begin
            if (lvl) begin
              pressed_q = 1'b1;
            end else begin
              countdown = ticks_cfg;
              fsm_code = CODE_DB_RELEASE;
            end
          end else begin
            pressed_q = 1'b1;
            fsm_code = CODE_WAIT_RELEASE;
          end
        end
        CODE_WAIT_RELEASE: begin
          pressed_q = 1'b0;
          if (!lvl) begin
            countdown = ticks_cfg;
            fsm_code = CODE_DB_RELEASE;
          end
        end
        CODE_DB_RELEASE: begin
          if (lvl) begin
            fsm_code = holdable_cfg ? CODE_ACTIVE : CODE_WAIT_RELEASE;
            pressed_q = holdable_cfg;
          end else if (countdown == '0) begin
            pressed_q = 1'b0;
            fsm_code = CODE_INACTIVE;
          end
        end
        default: begin
          pressed_q = 1'b0;
          fsm_code = CODE_INACTIVE;
          if (lvl) begin
            countdown = ticks_cfg;
            fsm_code = CODE_DB_PRESS;
          end
        end
      endcase
    end
    res.pressed = pressed_q;
    res.state_code = fsm_code;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      fsm_code = CODE_INACTIVE;
      countdown = '0;
      pressed_q = 1'b0;
      ticks_cfg = TICKS_RESET;
      holdable_cfg = 1'b0;
      expected_q.delete();
      errors = 0;
      checked = 0;
      codes_seen = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got.pressed = pressed;
        got.state_code = state_code;
        checked++;
        codes_seen[state_code] = 1'b1;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transfer waiting", 0, 32'(got));
        end else begin
          want = expected_q.pop_front();
          if (got.pressed !== want.pressed) begin
            report_mismatch("pressed", 32'(want.pressed), 32'(got.pressed));
          end
          if (got.state_code !== want.state_code) begin
            report_mismatch("state_code", 32'(want.state_code), 32'(got.state_code));
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(debounce_step(kind, pin_level));
      if (wr_en) begin
        if (wr_index == REG_DEBOUNCE_TICKS) ticks_cfg = wr_data;
        else if (wr_index == REG_HOLDABLE) holdable_cfg = wr_data[0];
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

/* tb/sv/button_debounce_fsm_top_test.sv */
// Testbench top for the push-button debouncer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module button_debounce_fsm_top_test;
  import bdf_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 kind = KIND_TICK;
  logic                 pin_level = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = REG_DEBOUNCE_TICKS;
  logic [TICK_W-1:0]    wr_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 pressed;
  logic [CODE_W-1:0]    state_code;

  int                   errors;
  int                   outstanding;
  int                   checked;
  logic [7:0]           codes_seen;

  int                   send_pct = 0;
  int                   recv_pct = 0;
  int                   hold_req = 0;
  int                   hold_ack = 0;
  int                   hold_left = 0;
  int                   transfers = 0;
  int                   ticks_sent = 0;
  int                   samples_sent = 0;
  logic [TICK_W-1:0]    ticks_setting = TICKS_RESET;

  button_debounce_fsm_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .pin_level  (pin_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pressed    (pressed),
    .state_code (state_code),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  debounce_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .pin_level   (pin_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pressed     (pressed),
    .state_code  (state_code),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .codes_seen  (codes_seen)
  );

  always #2 clk = ~clk;

  initial begin
    #1000000;
    $display("button_debounce_fsm_top_test: errors");
    $finish;
  end

  // A long hold-off is requested by the stimulus and counted out here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = 47;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic send_item(input logic item_kind, input logic lvl);
    kind <= item_kind;
    pin_level <= lvl;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    transfers++;
    if (item_kind == KIND_SAMPLE) samples_sent++;
    else ticks_sent++;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [TICK_W-1:0] ticks, input logic hold);
    drain_results();
    wr_en <= 1'b1;
    wr_index <= REG_DEBOUNCE_TICKS;
    wr_data <= ticks;
    @(posedge clk);
    wr_index <= REG_HOLDABLE;
    wr_data <= TICK_W'(hold);
    @(posedge clk);
    wr_en <= 1'b0;
    ticks_setting = ticks;
  endtask

  // Samples mostly at one level with an occasional bounce, ticks in between.
  task automatic level_run(input logic lvl, input int n, input int span);
    repeat (n) begin
      repeat ($urandom_range(0, span)) send_item(KIND_TICK, 1'($urandom_range(1)));
      send_item(KIND_SAMPLE, ($urandom_range(7) == 0) ? !lvl : lvl);
    end
  endtask

  task automatic press_or_noise();
    int span;
    span = (ticks_setting <= 6) ? int'(ticks_setting) + 1 : 3;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      level_run(1'b1, $urandom_range(1, 6), span);
      level_run(1'b0, $urandom_range(1, 6), span);
    end
  endtask

  initial begin
    int goal;
    int base;
    int guard;
    logic [TICK_W-1:0] ticks_pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(KIND_TICK, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);

    configure('0, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b0);

    configure(16'd2, 1'b1);
    send_item(KIND_SAMPLE, 1'b1);
    repeat (3) send_item(KIND_TICK, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b0);

    // The running release countdown must not pick up the new tick count.
    configure(16'hFFFF, 1'b1);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_SAMPLE, 1'b0);
    send_item(KIND_SAMPLE, 1'b1);
    send_item(KIND_SAMPLE, 1'b1);

    base = transfers;
    for (int phase = 0; phase < 3; phase++) begin
      send_pct = (phase == 0) ? 10 : (phase == 1) ? 56 : 0;
      recv_pct = (phase == 0) ? 56 : (phase == 1) ? 10 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: ticks_pick = '0;
          1: ticks_pick = TICK_W'($urandom_range(1, 6));
          2: ticks_pick = TICK_W'($urandom_range(1, 3));
          default: ticks_pick = (phase == 2) ? 16'hFFFF : TICK_W'($urandom_range(0, 8));
        endcase
        configure(ticks_pick, 1'($urandom_range(1)));
        if (seg == 1) hold_req <= hold_req + 1;
        goal = base + (phase * 4 + seg + 1) * 133;
        while (transfers < goal) press_or_noise();
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 1000);
    repeat (4) @(posedge clk);

    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    $display("Covered %0d transfers (%0d ticks, %0d samples) over tick counts 0 to 65535,",
             transfers, ticks_sent, samples_sent);
    $display("both press modes and three flow-control mixes; %0d results checked, codes %b.",
             checked, codes_seen[4:0]);
    if (errors == 0 && outstanding == 0) begin
      $display("button_debounce_fsm_top_test: clean");
    end else begin
      $display("button_debounce_fsm_top_test: errors");
    end
    $finish;
  end

endmodule
